/* rtl/core/u8dv_pkg.sv */
// shared types, constants and lookup functions for the utf-8 decode/width block
// no dependencies
package u8dv_pkg;

    localparam int TOTAL_WIDTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH          = 2;
    localparam int S_TDATA_W            = 8;
    localparam int M_TDATA_W            = 48;
    localparam int M_TUSER_W            = 2;
    localparam int CP_W                 = 21;
    localparam int LEN_W                = 3;
    localparam int CW_W                 = 2;
    localparam int TW_OUT_W             = 16;

    localparam logic [CW_W-1:0] WIDTH_ZERO   = 2'd0;
    localparam logic [CW_W-1:0] WIDTH_NORMAL = 2'd1;
    localparam logic [CW_W-1:0] WIDTH_WIDE   = 2'd2;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_len;
        logic             char_valid;
        logic             eos;
    } u8dv_entry_t;

    localparam logic [CP_W-1:0] ZERO_LO [0:7] = '{
        21'h00000, 21'h0200B, 21'h0FEFF, 21'h00300,
        21'h01DC0, 21'h020D0, 21'h0FE00, 21'h0FE20
    };
    localparam logic [CP_W-1:0] ZERO_HI [0:7] = '{
        21'h00000, 21'h0200F, 21'h0FEFF, 21'h0036F,
        21'h01DFF, 21'h020FF, 21'h0FE0F, 21'h0FE2F
    };

    localparam logic [CP_W-1:0] WIDE_LO [0:25] = '{
        21'h01100, 21'h02329, 21'h02E80, 21'h02E9B, 21'h02F00, 21'h02FF0,
        21'h03000, 21'h03041, 21'h03099, 21'h03105, 21'h03131, 21'h03190,
        21'h031F0, 21'h03220, 21'h03250, 21'h04E00, 21'h0A490, 21'h0AC00,
        21'h0F900, 21'h0FE10, 21'h0FE30, 21'h0FF01, 21'h0FFE0, 21'h1F000,
        21'h20000, 21'h30000
    };
    localparam logic [CP_W-1:0] WIDE_HI [0:25] = '{
        21'h0115F, 21'h0232A, 21'h02E99, 21'h02EF3, 21'h02FD5, 21'h02FFB,
        21'h0303E, 21'h03096, 21'h030FF, 21'h0312F, 21'h0318E, 21'h031E3,
        21'h0321E, 21'h03247, 21'h04DBF, 21'h0A48C, 21'h0A4C6, 21'h0D7A3,
        21'h0FAFF, 21'h0FE19, 21'h0FE6B, 21'h0FF60, 21'h0FFE6, 21'h1F9FF,
        21'h2FFFD, 21'h3FFFD
    };

    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] n;
        n = 3'd0;
        priority if (b[7] == 1'b0)        n = 3'd1;
        else if (b[7:5] == 3'b110)        n = 3'd2;
        else if (b[7:4] == 4'b1110)       n = 3'd3;
        else if (b[7:3] == 5'b11110)      n = 3'd4;
        else                              n = 3'd0;
        return n;
    endfunction

    function automatic logic [CW_W-1:0] char_columns(input logic [CP_W-1:0] cp);
        logic zero_hit;
        logic wide_hit;
        logic ctrl_hit;
        logic [CW_W-1:0] w;
        zero_hit = 1'b0;
        wide_hit = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (cp >= ZERO_LO[i] && cp <= ZERO_HI[i]) begin
                zero_hit = 1'b1;
            end
        end
        for (int i = 0; i < 26; i++) begin
            if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
                wide_hit = 1'b1;
            end
        end
        ctrl_hit = (cp < 21'h20) || (cp >= 21'h7F && cp < 21'hA0);
        priority if (zero_hit || ctrl_hit) w = WIDTH_ZERO;
        else if (wide_hit)                 w = WIDTH_WIDE;
        else                               w = WIDTH_NORMAL;
        return w;
    endfunction

endpackage

/* rtl/core/u8dv_front.sv */
// front end: collects bytes of a sequence, validates it and queues one entry per result
// depends on u8dv_pkg
module u8dv_front
    import u8dv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 push,
    output u8dv_entry_t          push_data
);

    logic [LEN_W-1:0] expected_reg, expected_next;
    logic [LEN_W-1:0] collected_reg, collected_next;
    logic             error_reg, error_next;
    logic [7:0]       lead_reg, lead_next;
    logic [7:0]       cont_reg [0:2];

    logic [LEN_W-1:0] lead_n;
    logic [LEN_W-1:0] len_cur;
    logic [LEN_W-1:0] col_cur;
    logic [7:0]       lead_cur, c0, c1, c2;
    logic             complete;
    logic             cont_ok;
    logic             seq_ok;
    logic [CP_W-1:0]  cp;

    assign lead_n   = lead_length(data_byte);
    assign len_cur  = (expected_reg == 3'd0) ? lead_n : expected_reg;
    assign col_cur  = (expected_reg == 3'd0) ? 3'd1 : collected_reg + 3'd1;
    assign lead_cur = (expected_reg == 3'd0) ? data_byte : lead_reg;
    assign c0       = (collected_reg == 3'd1) ? data_byte : cont_reg[0];
    assign c1       = (collected_reg == 3'd2) ? data_byte : cont_reg[1];
    assign c2       = (collected_reg == 3'd3) ? data_byte : cont_reg[2];
    assign complete = (len_cur != 3'd0) && (col_cur == len_cur);

    always_comb begin
        cont_ok = 1'b1;
        if (len_cur >= 3'd2 && c0[7:6] != 2'b10) cont_ok = 1'b0;
        if (len_cur >= 3'd3 && c1[7:6] != 2'b10) cont_ok = 1'b0;
        if (len_cur == 3'd4 && c2[7:6] != 2'b10) cont_ok = 1'b0;
    end

    always_comb begin
        cp     = '0;
        seq_ok = 1'b0;
        unique case (len_cur)
            3'd1: begin
                cp     = {14'd0, lead_cur[6:0]};
                seq_ok = 1'b1;
            end
            3'd2: begin
                cp     = {10'd0, lead_cur[4:0], c0[5:0]};
                seq_ok = (cp >= 21'h80);
            end
            3'd3: begin
                cp     = {5'd0, lead_cur[3:0], c0[5:0], c1[5:0]};
                seq_ok = (cp >= 21'h800) && !(cp >= 21'hD800 && cp <= 21'hDFFF);
            end
            3'd4: begin
                cp     = {lead_cur[2:0], c0[5:0], c1[5:0], c2[5:0]};
                seq_ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
            end
            default: begin
                cp     = '0;
                seq_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        expected_next  = expected_reg;
        collected_next = collected_reg;
        error_next     = error_reg;
        lead_next      = lead_reg;
        push           = 1'b0;
        push_data      = '{code_point: '0, seq_len: '0, char_valid: 1'b0, eos: last_byte};
        if (in_accept) begin
            priority if (error_reg) begin
                if (last_byte) begin
                    push           = 1'b1;
                    error_next     = 1'b0;
                    expected_next  = 3'd0;
                    collected_next = 3'd0;
                end
            end else if (expected_reg == 3'd0 && lead_n == 3'd0) begin
                // bad lead byte
                push       = 1'b1;
                error_next = !last_byte;
            end else begin
                if (expected_reg == 3'd0) begin
                    lead_next = data_byte;
                end
                if (complete) begin
                    push           = 1'b1;
                    push_data.seq_len    = len_cur;
                    push_data.char_valid = cont_ok && seq_ok;
                    push_data.code_point = (cont_ok && seq_ok) ? cp : '0;
                    error_next     = !(cont_ok && seq_ok) && !last_byte;
                    expected_next  = 3'd0;
                    collected_next = 3'd0;
                end else if (last_byte) begin
                    // truncated sequence
                    push           = 1'b1;
                    expected_next  = 3'd0;
                    collected_next = 3'd0;
                end else begin
                    expected_next  = len_cur;
                    collected_next = col_cur;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg  <= '0;
            collected_reg <= '0;
            error_reg     <= 1'b0;
            lead_reg      <= '0;
        end else begin
            expected_reg  <= expected_next;
            collected_reg <= collected_next;
            error_reg     <= error_next;
            lead_reg      <= lead_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && !error_reg && expected_reg != 3'd0) begin
            unique case (collected_reg)
                3'd1:    cont_reg[0] <= data_byte;
                3'd2:    cont_reg[1] <= data_byte;
                3'd3:    cont_reg[2] <= data_byte;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/u8dv_queue.sv */
// short register queue between front and back ends
// depends on u8dv_pkg
module u8dv_queue
    import u8dv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  u8dv_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output u8dv_entry_t pop_data,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    u8dv_entry_t      slot_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/u8dv_back.sv */
// back end: width lookup, saturating running width and output register
// depends on u8dv_pkg
module u8dv_back
    import u8dv_pkg::*;
#(
    parameter int TOTAL_WIDTH_BITS = TOTAL_WIDTH_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  u8dv_entry_t          q_data,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam int SUM_W = TOTAL_WIDTH_BITS + 1;
    localparam int EXT_W = TOTAL_WIDTH_BITS + TW_OUT_W;

    logic [TOTAL_WIDTH_BITS-1:0] wsum_reg, wsum_next;
    logic                        m_valid_reg, m_valid_next;
    logic [CP_W-1:0]             cp_reg;
    logic [LEN_W-1:0]            len_reg;
    logic                        cvalid_reg;
    logic [CW_W-1:0]             cw_reg;
    logic [TW_OUT_W-1:0]         tw_reg;
    logic                        eos_reg;

    logic [CW_W-1:0]             cw;
    logic [SUM_W-1:0]            sum_wide;
    logic [TOTAL_WIDTH_BITS-1:0] sum_sat;
    logic [TOTAL_WIDTH_BITS-1:0] shown;
    logic [EXT_W-1:0]            shown_ext;

    assign q_pop     = !q_empty && (!m_valid_reg || m_tready);
    assign cw        = q_data.char_valid ? char_columns(q_data.code_point) : WIDTH_ZERO;
    assign sum_wide  = {1'b0, wsum_reg} + SUM_W'(cw);
    assign sum_sat   = sum_wide[SUM_W-1] ? '1 : sum_wide[TOTAL_WIDTH_BITS-1:0];
    assign shown     = q_data.char_valid ? sum_sat : wsum_reg;
    assign shown_ext = EXT_W'(shown);

    always_comb begin
        wsum_next    = wsum_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            m_valid_next = 1'b1;
            wsum_next    = q_data.eos ? '0 : shown;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsum_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wsum_reg    <= wsum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cp_reg     <= q_data.code_point;
            len_reg    <= q_data.seq_len;
            cvalid_reg <= q_data.char_valid;
            cw_reg     <= cw;
            tw_reg     <= shown_ext[TW_OUT_W-1:0];
            eos_reg    <= q_data.eos;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, tw_reg, cw_reg, len_reg, cp_reg};
    assign m_tuser  = {cvalid_reg, cvalid_reg};
    assign m_tlast  = eos_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !cvalid_reg) |-> (cp_reg == '0 && cw_reg == WIDTH_ZERO))
        else $error("invalid result carries character data");
    a_valid_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && cvalid_reg) |-> (len_reg != 3'd0 && len_reg <= 3'd4))
        else $error("valid character with bad sequence length");
    a_pop_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid_reg)
        else $error("popped entry not presented");
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_data.eos) |=> (wsum_reg == '0))
        else $error("running width not cleared at end of string");
`endif

endmodule

/* rtl/core/utf8_decode_validate_width.sv */
// utf-8 decoder/validator with display width: a byte that closes a sequence, a bad lead
// byte or an s_tlast byte gives a result via the queue and output register; others give none
// one byte per cycle through the combinational front decode while the 2-entry queue has room
// the output register takes a new word while the downstream side drains the held one
// aresetn synchronous: clears sequence state, error flag, running width and queue
// depends on u8dv_pkg, u8dv_front, u8dv_queue, u8dv_back
module utf8_decode_validate_width
    import u8dv_pkg::*;
#(
    parameter int TOTAL_WIDTH_BITS = TOTAL_WIDTH_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] sequence_length,
                                            // [25:24] char_width, [41:26] running_width
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] char_valid, [1] copy of char_valid
    output logic                 m_tlast
);

    logic        in_accept;
    logic        push;
    u8dv_entry_t push_data;
    logic        q_full;
    logic        q_pop;
    u8dv_entry_t q_data;
    logic        q_empty;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    u8dv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .data_byte (s_tdata[7:0]),
        .last_byte (s_tlast),
        .push      (push),
        .push_data (push_data)
    );

    u8dv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    u8dv_back #(
        .TOTAL_WIDTH_BITS (TOTAL_WIDTH_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
